// ===== hdl/msb_first_bit_field_reader_macros.svh =====
// Assertion macros used by the checker file.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef MSB_FIRST_BIT_FIELD_READER_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_READER_MACROS_SVH

// A property checked at every clock edge outside reset.
`define MSBFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that must hold in the first cycle after reset is released.
`define MSBFR_ASSERT_POST_RESET(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) $past(!rst_n) |-> (expr)) \
    else $error(msg);

`endif

// ===== hdl/msbfr_pkg.sv =====
`default_nettype none

package msbfr_pkg;

  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned LOC_W   = 13;
  localparam int unsigned VALUE_W = 32;
  // A field of up to 32 bits at any bit offset touches at most five bytes.
  localparam int unsigned WIN_W   = 40;
  localparam int unsigned QDEPTH  = 2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_READ = 2'd1,
    OP_PEEK = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  bit_count;
    logic [LOC_W-1:0]  bit_location;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

`default_nettype wire

// ===== hdl/msbfr_ram.sv =====
`default_nettype none

module msbfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/msbfr_front.sv =====
`default_nettype none

module msbfr_front #(
  parameter int unsigned MAX_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_op,
  input  logic [msbfr_pkg::ADDR_W-1:0]    in_address,
  input  logic [msbfr_pkg::DATA_W-1:0]    in_data,
  input  logic [msbfr_pkg::CNT_W-1:0]     in_bit_count,
  input  logic [msbfr_pkg::LOC_W-1:0]     in_bit_location,
  output msbfr_pkg::queue_head_t          head,
  input  logic                            pop
);

  import msbfr_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  cmd_t             q_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;
  cmd_t             cmd_c;
  logic             push;

  assign busy = !rst_n || (fill_r == (PTR_W+1)'(QDEPTH));
  assign push = start && !busy;

  // Counts above the widest supported field are saturated here, once.
  always_comb begin
    cmd_c.op           = op_t'(in_op);
    cmd_c.address      = in_address;
    cmd_c.data         = in_data;
    cmd_c.bit_count    = (in_bit_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : in_bit_count;
    cmd_c.bit_location = in_bit_location;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_c;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hdl/msbfr_back.sv =====
`default_nettype none

module msbfr_back #(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  msbfr_pkg::queue_head_t          head,
  output logic                            pop,
  output logic                            out_strobe,
  output logic [msbfr_pkg::VALUE_W-1:0]   out_value,
  output logic [msbfr_pkg::LOC_W-1:0]     out_position
);

  import msbfr_pkg::*;

  // Store depth must be a power of two (unchecked); addresses wrap by truncation.
  localparam int unsigned AW = $clog2(STORE_BYTES);

  back_state_t        state_r, state_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [2:0]         off_r, off_nxt;
  logic [AW-1:0]      faddr_r, faddr_nxt;
  logic [2:0]         left_r, left_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   end_r, end_nxt;
  logic               is_read_r, is_read_nxt;
  logic [WIN_W-1:0]   acc_r, acc_nxt;
  logic               rvalid_r, rvalid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [LOC_W-1:0]   out_position_r, out_position_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [DATA_W-1:0]  wdata;
  logic [AW-1:0]      raddr;
  logic [DATA_W-1:0]  rdata;

  msbfr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  function automatic logic [LOC_W-1:0] pos_of(logic [AW-1:0] i, logic [2:0] o);
    pos_of = LOC_W'({i, o});
  endfunction

  always_comb begin
    logic [AW-1:0]    start_idx;
    logic [2:0]       start_off;
    logic [CNT_W-1:0] end_c;
    logic [CNT_W-1:0] round_c;
    logic [2:0]       drop_c;
    logic [WIN_W-1:0] win_c;
    logic [VALUE_W:0] mask_c;

    state_nxt        = state_r;
    idx_nxt          = idx_r;
    off_nxt          = off_r;
    faddr_nxt        = faddr_r;
    left_nxt         = left_r;
    n_nxt            = n_r;
    end_nxt          = end_r;
    is_read_nxt      = is_read_r;
    acc_nxt          = acc_r;
    rvalid_nxt       = 1'b0;
    out_valid_nxt    = 1'b0;
    out_value_nxt    = out_value_r;
    out_position_nxt = out_position_r;
    pop              = 1'b0;
    we               = 1'b0;
    waddr            = AW'(head.cmd.address);
    wdata            = head.cmd.data;
    raddr            = faddr_r;

    // A peek starts at its own location, a read at the current position.
    start_idx = (head.cmd.op == OP_PEEK) ? AW'(head.cmd.bit_location[LOC_W-1:3]) : idx_r;
    start_off = (head.cmd.op == OP_PEEK) ? head.cmd.bit_location[2:0] : off_r;
    end_c     = CNT_W'(start_off) + head.cmd.bit_count;
    round_c   = end_c + CNT_W'(7);

    // Bits past the end of the field in the last fetched byte are dropped.
    drop_c = 3'd0 - end_r[2:0];
    win_c  = acc_r >> drop_c;
    mask_c = ((VALUE_W+1)'(1) << n_r) - (VALUE_W+1)'(1);

    if (rvalid_r) begin
      acc_nxt = {acc_r[WIN_W-DATA_W-1:0], rdata};
    end

    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.cmd.op) inside
            OP_LOAD: begin
              we               = 1'b1;
              out_valid_nxt    = 1'b1;
              out_value_nxt    = '0;
              out_position_nxt = pos_of(idx_r, off_r);
            end
            OP_SET: begin
              idx_nxt          = AW'(head.cmd.bit_location[LOC_W-1:3]);
              off_nxt          = head.cmd.bit_location[2:0];
              out_valid_nxt    = 1'b1;
              out_value_nxt    = '0;
              out_position_nxt = pos_of(AW'(head.cmd.bit_location[LOC_W-1:3]),
                                        head.cmd.bit_location[2:0]);
            end
            OP_READ, OP_PEEK: begin
              if (head.cmd.bit_count == '0) begin
                out_valid_nxt    = 1'b1;
                out_value_nxt    = '0;
                out_position_nxt = pos_of(idx_r, off_r);
              end else begin
                faddr_nxt   = start_idx;
                left_nxt    = round_c[CNT_W-1:3];
                n_nxt       = head.cmd.bit_count;
                end_nxt     = end_c;
                is_read_nxt = (head.cmd.op == OP_READ);
                acc_nxt     = '0;
                state_nxt   = ST_FETCH;
              end
            end
          endcase
        end
      end
      ST_FETCH: begin
        rvalid_nxt = 1'b1;
        faddr_nxt  = faddr_r + AW'(1);
        left_nxt   = left_r - 3'd1;
        if (left_r == 3'd1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = win_c[VALUE_W-1:0] & mask_c[VALUE_W-1:0];
        if (is_read_r) begin
          idx_nxt          = idx_r + AW'(end_r[CNT_W-1:3]);
          off_nxt          = end_r[2:0];
          out_position_nxt = pos_of(idx_r + AW'(end_r[CNT_W-1:3]), end_r[2:0]);
        end else begin
          out_position_nxt = pos_of(idx_r, off_r);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idx_r          <= '0;
      off_r          <= '0;
      rvalid_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      out_position_r <= '0;
    end else begin
      state_r        <= state_nxt;
      idx_r          <= idx_nxt;
      off_r          <= off_nxt;
      rvalid_r       <= rvalid_nxt;
      out_valid_r    <= out_valid_nxt;
      out_position_r <= out_position_nxt;
    end
  end

  always_ff @(posedge clk) begin
    faddr_r     <= faddr_nxt;
    left_r      <= left_nxt;
    n_r         <= n_nxt;
    end_r       <= end_nxt;
    is_read_r   <= is_read_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_strobe   = out_valid_r && rst_n;
  assign out_value    = out_value_r;
  assign out_position = out_position_r;

endmodule

`default_nettype wire

// ===== hdl/msb_first_bit_field_reader.sv =====
`default_nettype none

// Channel   Handshake          Ports
// input     start / busy       in_op, in_address, in_data, in_bit_count, in_bit_location
// result    out_strobe         out_value, out_position
//
// Load, set and zero-count items finish in the execution unit straight from idle; a read or peek
// fetches nb = ceil((bit offset + count) / 8) bytes, at most 5, then drains and finishes, with the
// byte-wide store read port fetching one byte per cycle.
// A two-entry command queue sits in front; busy is high while it is full or in reset.
// Reset puts the read position at bit 0 and empties the queue; store bytes are kept.
// Each result is shown for one cycle; the receiver cannot stall it.

module msb_first_bit_field_reader #(
  parameter int unsigned STORE_BYTES = 1024,
  parameter int unsigned MAX_BITS    = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_op,
  input  logic [msbfr_pkg::ADDR_W-1:0]    in_address,
  input  logic [msbfr_pkg::DATA_W-1:0]    in_data,
  input  logic [msbfr_pkg::CNT_W-1:0]     in_bit_count,
  input  logic [msbfr_pkg::LOC_W-1:0]     in_bit_location,
  output logic                            out_strobe,
  output logic [msbfr_pkg::VALUE_W-1:0]   out_value,
  output logic [msbfr_pkg::LOC_W-1:0]     out_position
);

  import msbfr_pkg::*;

  queue_head_t head;
  logic        pop;

  msbfr_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_address      (in_address),
    .in_data         (in_data),
    .in_bit_count    (in_bit_count),
    .in_bit_location (in_bit_location),
    .head            (head),
    .pop             (pop)
  );

  msbfr_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_position (out_position)
  );

endmodule

`default_nettype wire

// ===== hdl/msbfr_checker.sv =====
`default_nettype none

`include "msb_first_bit_field_reader_macros.svh"

module msbfr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_strobe,
  input wire logic [msbfr_pkg::LOC_W-1:0] out_position
);

  `MSBFR_ASSERT_POST_RESET(a_idle_after_reset, !busy && !out_strobe, "not idle after reset")

  // The position only moves together with a result transfer.
  `MSBFR_ASSERT(a_position_holds, (!out_strobe && $past(rst_n)) |-> $stable(out_position), "position moved without a result")

  // The queue fills only through an input transfer.
  `MSBFR_ASSERT(a_busy_needs_start, ($rose(busy) && $past(rst_n)) |-> $past(start), "busy rose without a transfer")

endmodule

bind msb_first_bit_field_reader msbfr_checker u_msbfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_position (out_position)
);

`default_nettype wire

// ===== bench/tb_msb_first_bit_field_reader.sv =====
`timescale 1ns / 1ps

module tb_msb_first_bit_field_reader;
  import msbfr_pkg::*;

  localparam int unsigned FIELD_MAX   = 32;
  localparam int unsigned STORE_SIZE  = 1024;
  localparam int unsigned TOTAL_ITEMS = 1950;
  localparam int unsigned TAIL_ITEMS  = 150;
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LOC_W-1:0]   position;
  } field_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_op = '0;
  logic [ADDR_W-1:0]  in_address = '0;
  logic [DATA_W-1:0]  in_data = '0;
  logic [CNT_W-1:0]   in_bit_count = '0;
  logic [LOC_W-1:0]   in_bit_location = '0;
  logic               out_strobe;
  logic [VALUE_W-1:0] out_value;
  logic [LOC_W-1:0]   out_position;

  // Commands waiting for the driver, and results still owed by the block.
  cmd_t          pending_cmds[$];
  field_result_t owed_results[$];
  cmd_t          active_cmd;

  // Shadow of the block as seen at transfer time.
  logic [DATA_W-1:0] store_img [STORE_SIZE];
  logic [LOC_W-1:0]  read_loc = '0;

  // Stimulus planning state: which bytes hold data and where reads will start.
  bit               written_map [STORE_SIZE];
  logic [LOC_W-1:0] plan_loc = '0;

  int unsigned queued_total = 0;
  int unsigned sent_total = 0;
  int unsigned taken_total = 0;
  int unsigned gap_left = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  msb_first_bit_field_reader uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_address     (in_address),
    .in_data        (in_data),
    .in_bit_count   (in_bit_count),
    .in_bit_location(in_bit_location),
    .out_strobe     (out_strobe),
    .out_value      (out_value),
    .out_position   (out_position)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned field_len(logic [CNT_W-1:0] count);
    return (count > FIELD_MAX) ? FIELD_MAX : int'(count);
  endfunction

  function automatic logic [VALUE_W-1:0] extract_field(logic [LOC_W-1:0] loc, int unsigned n);
    logic [VALUE_W-1:0] acc;
    logic [LOC_W-1:0]   b;
    acc = '0;
    for (int unsigned k = 0; k < n; k++) begin
      b = loc + LOC_W'(k);
      acc = {acc[VALUE_W-2:0], store_img[b[LOC_W-1:3]][3'd7 - b[2:0]]};
    end
    return acc;
  endfunction

  // Applies one transferred command to the shadow and returns the result it owes.
  function automatic field_result_t apply_command(cmd_t c);
    field_result_t r;
    r.value = '0;
    case (c.op)
      OP_LOAD: store_img[c.address] = c.data;
      OP_READ: begin
        r.value  = extract_field(read_loc, field_len(c.bit_count));
        read_loc = read_loc + LOC_W'(field_len(c.bit_count));
      end
      OP_PEEK: r.value = extract_field(c.bit_location, field_len(c.bit_count));
      OP_SET:  read_loc = c.bit_location;
      default: ;
    endcase
    r.position = read_loc;
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op           = op_t'($urandom_range(3));
    c.address      = ADDR_W'($urandom_range(STORE_SIZE - 1));
    c.data         = DATA_W'($urandom_range(255));
    c.bit_count    = CNT_W'($urandom_range(63));
    c.bit_location = LOC_W'($urandom_range(8191));
    return c;
  endfunction

  function automatic cmd_t make_cmd(op_t op, int unsigned address, int unsigned data,
                                    int unsigned count, int unsigned loc);
    cmd_t c;
    c.op           = op;
    c.address      = ADDR_W'(address);
    c.data         = DATA_W'(data);
    c.bit_count    = CNT_W'(count);
    c.bit_location = LOC_W'(loc);
    return c;
  endfunction

  // Mostly ordinary field widths, with empty and oversized counts mixed in.
  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CNT_W'($urandom_range(63, 33));
      default: return CNT_W'($urandom_range(32, 1));
    endcase
  endfunction

  // Locations near the top of the store make fields wrap to byte zero.
  function automatic logic [LOC_W-1:0] pick_location();
    if ($urandom_range(5) == 0)
      return LOC_W'(8191 - $urandom_range(40));
    return LOC_W'($urandom_range(8191));
  endfunction

  // Queues a command, first loading any byte that a read or peek would touch
  // before it has ever been written.
  task automatic queue_command(cmd_t c);
    cmd_t             fill;
    logic [LOC_W-1:0] at;
    logic [LOC_W-1:0] b;
    int unsigned      n;
    n  = field_len(c.bit_count);
    at = (c.op == OP_PEEK) ? c.bit_location : plan_loc;
    if (c.op == OP_READ || c.op == OP_PEEK) begin
      for (int unsigned k = 0; k < n; k++) begin
        b = at + LOC_W'(k);
        if (!written_map[b[LOC_W-1:3]]) begin
          fill         = random_cmd();
          fill.op      = OP_LOAD;
          fill.address = b[LOC_W-1:3];
          written_map[b[LOC_W-1:3]] = 1'b1;
          pending_cmds.push_back(fill);
          queued_total++;
        end
      end
    end
    case (c.op)
      OP_LOAD: written_map[c.address] = 1'b1;
      OP_READ: plan_loc = plan_loc + LOC_W'(n);
      OP_SET:  plan_loc = c.bit_location;
      default: ;
    endcase
    pending_cmds.push_back(c);
    queued_total++;
  endtask

  initial begin
    cmd_t        c;
    int unsigned sel;

    // Bytes at both ends of the store so that fields can wrap.
    queue_command(make_cmd(OP_LOAD, 0, 8'hFF, 0, 0));
    queue_command(make_cmd(OP_LOAD, 1, 8'h00, 0, 0));
    queue_command(make_cmd(OP_LOAD, 2, 8'h5A, 0, 0));
    queue_command(make_cmd(OP_LOAD, 3, 8'hC3, 0, 0));
    queue_command(make_cmd(OP_LOAD, 4, 8'h96, 0, 0));
    queue_command(make_cmd(OP_LOAD, 1020, 8'h81, 0, 0));
    queue_command(make_cmd(OP_LOAD, 1021, 8'h7E, 0, 0));
    queue_command(make_cmd(OP_LOAD, 1022, 8'hA5, 0, 0));
    queue_command(make_cmd(OP_LOAD, 1023, 8'h01, 0, 0));
    queue_command(make_cmd(OP_READ, 1023, 255, 0, 8191));
    queue_command(make_cmd(OP_READ, 0, 0, 1, 0));
    queue_command(make_cmd(OP_READ, 0, 0, 7, 0));
    queue_command(make_cmd(OP_READ, 0, 0, 32, 0));
    queue_command(make_cmd(OP_SET, 0, 0, 0, 8180));
    queue_command(make_cmd(OP_READ, 0, 0, 32, 0));
    queue_command(make_cmd(OP_SET, 0, 0, 0, 8160));
    queue_command(make_cmd(OP_READ, 0, 0, 63, 0));
    queue_command(make_cmd(OP_PEEK, 0, 0, 32, 8191));
    queue_command(make_cmd(OP_PEEK, 0, 0, 0, 8191));
    queue_command(make_cmd(OP_PEEK, 0, 0, 40, 3));
    queue_command(make_cmd(OP_PEEK, 0, 0, 1, 0));
    queue_command(make_cmd(OP_SET, 1023, 255, 63, 8191));
    queue_command(make_cmd(OP_READ, 0, 0, 1, 0));
    queue_command(make_cmd(OP_LOAD, 1023, 8'h00, 0, 0));
    queue_command(make_cmd(OP_PEEK, 0, 0, 16, 8184));

    while (queued_total < TOTAL_ITEMS) begin
      c   = random_cmd();
      sel = $urandom_range(99);
      if (sel < 20) begin
        c.op = OP_LOAD;
      end else if (sel < 55) begin
        c.op        = OP_READ;
        c.bit_count = pick_count();
      end else if (sel < 75) begin
        c.op           = OP_PEEK;
        c.bit_count    = pick_count();
        c.bit_location = pick_location();
      end else begin
        c.op           = OP_SET;
        c.bit_location = pick_location();
      end
      queue_command(c);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (taken_total < queued_total || owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("msb_first_bit_field_reader regression: pass");
    else
      $display("msb_first_bit_field_reader regression: fail");
    $finish;
  end

  always @(posedge clk) begin : drive
    logic next_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        owed_results.push_back(apply_command(active_cmd));
        taken_total++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          // Idle bursts come in phases; every fourth phase and the tail run flat out.
          if (pending_cmds.size() > TAIL_ITEMS && ((sent_total / 200) % 4) != 3 &&
              $urandom_range(7) == 0) begin
            gap_left = $urandom_range(6, 1) - 1;
          end else begin
            active_cmd = pending_cmds.pop_front();
            sent_total++;
            in_op           <= active_cmd.op;
            in_address      <= active_cmd.address;
            in_data         <= active_cmd.data;
            in_bit_count    <= active_cmd.bit_count;
            in_bit_location <= active_cmd.bit_location;
            next_start = 1'b1;
          end
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk) begin : observe
    field_result_t want;
    if (rst_n && out_strobe) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: value %h position %0d", out_value, out_position);
      end else begin
        want = owed_results.pop_front();
        if (out_value !== want.value || out_position !== want.position) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result mismatch: expected value %h position %0d, got value %h position %0d",
                     want.value, want.position, out_value, out_position);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((start && !busy) || out_strobe)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("msb_first_bit_field_reader regression: fail");
        $finish;
      end
    end
  end

endmodule
